// ===== rtl/tks_pkg.sv =====
// Package for the top-k score selector: widths, item and result types,
// the slot and cell control structs, and the keep count helper.
// No dependencies; every other file imports it.
package tks_pkg;

   // Number of cells in the chain and widths of the fields.
   localparam int MAX_KEEP = 16;
   localparam int KEEP_W   = 5;
   localparam int RANK_W   = 4;
   localparam int SCORE_W  = 16;
   localparam int INDEX_W  = 16;

   // Keep count after reset, and the largest item index.
   localparam logic [KEEP_W-1:0]  KEEP_RESET = KEEP_W'((MAX_KEEP < 16) ? MAX_KEEP : 16);
   localparam logic [INDEX_W-1:0] INDEX_MAX  = '1;

   // One input item.
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               end_of_set;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [INDEX_W-1:0] item_index;
      logic [SCORE_W-1:0] item_score;
      logic               slot_valid;
      logic               last_rank;
      logic               overflow;
   } rsp_type;

   // Contents of one slot of the kept list.
   typedef struct packed {
      logic               used;
      logic [SCORE_W-1:0] score;
      logic [INDEX_W-1:0] index;
   } slot_type;

   // Control that the top level hands to each cell.
   typedef struct packed {
      logic active;    // cell lies below the keep count
      logic is_last;   // cell holds the lowest kept rank
      logic clear;     // keep count write drops this cell
      logic insert;    // the incoming score enters the list
      logic shift;     // move the list one rank toward rank 0
   } cell_ctrl_type;

   // Status that each cell reports.
   typedef struct packed {
      logic take;      // new score belongs at or above this cell
      logic gt;        // new score beats this cell's score, or cell is empty
   } cell_stat_type;

   // Effective keep count: zero acts as one, large values saturate.
   function automatic logic [KEEP_W-1:0] eff_keep(input logic [KEEP_W-1:0] value);
      logic [KEEP_W-1:0] result;
      if (value == '0) begin
         result = KEEP_W'(1);
      end else if (value > KEEP_W'(MAX_KEEP)) begin
         result = KEEP_W'(MAX_KEEP);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

// ===== rtl/tks_cell.sv =====
// One cell of the insertion chain: holds one slot of the sorted list.
// Depends on tks_pkg for the slot and control structs.
module tks_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tks_pkg::cell_ctrl_type ctrl,
   input  tks_pkg::slot_type      new_slot,
   input  tks_pkg::slot_type      left_slot,
   input  logic                   left_take,
   input  tks_pkg::slot_type      right_slot,
   output tks_pkg::slot_type      slot,
   output tks_pkg::cell_stat_type stat
);
   import tks_pkg::*;

   slot_type slot_ff, slot_in;
   logic     ge;

   // Compare the broadcast score against the held one.
   always_comb begin
      ge       = !slot_ff.used || (new_slot.score >= slot_ff.score);
      stat.gt  = !slot_ff.used || (new_slot.score > slot_ff.score);
      stat.take = ctrl.is_last ? stat.gt : ge;
   end

   // Next slot value: clear, shift out, take the new item or the left neighbor's.
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.clear) begin
         slot_in = '0;
      end else if (ctrl.shift) begin
         slot_in = right_slot;
      end else if (ctrl.insert && ctrl.active && stat.take) begin
         slot_in = left_take ? left_slot : new_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

// ===== rtl/top_k_score_selector.sv =====
// Top level of the top-k score selector: cell chain, index counter,
// result register and keep count register. Depends on tks_pkg and tks_cell.
//
// The block keeps the keep_count best scores of a set, best first, in a chain
// of cells that compare every incoming score at once, so one item is taken
// each cycle while a set streams in. The item with end_of_set is inserted like
// any other; the chain then shifts toward rank 0 until the effective keep count
// of results has left, one result item per cycle unless rsp_stall holds results
// back, and req_stall stays high for that time. The shift pulls empty slots in from the tail,
// so the list is clear when the last result leaves. Write keep_count only
// while no set is being reported.
module top_k_score_selector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  tks_pkg::req_type            req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tks_pkg::rsp_type            rsp_item,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tks_pkg::KEEP_W-1:0]  csr_data
);
   import tks_pkg::*;

   logic [KEEP_W-1:0]  keep_ff, keep_in;
   logic [INDEX_W-1:0] counter_ff, counter_in;
   logic               taken_ff, taken_in;
   logic               overflow_ff, overflow_in;
   logic               emit_ovf_ff, emit_ovf_in;
   logic               busy_ff, busy_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [KEEP_W-1:0]  keep_eff, new_eff;
   logic               req_fire, csr_fire, insert_en, emit_step, at_last;
   logic [MAX_KEEP-1:0] last_hit;
   slot_type           new_slot;
   slot_type           slots [MAX_KEEP];
   cell_stat_type      stats [MAX_KEEP];

   // Handshakes.
   assign req_stall = busy_ff;
   assign csr_ready = !busy_ff;
   assign req_fire  = req_valid && !busy_ff;
   assign csr_fire  = csr_valid && !busy_ff;

   assign keep_eff = eff_keep(keep_ff);
   assign new_eff  = eff_keep(csr_data);

   // The new item enters when the index has not run out and the last kept slot is empty or beaten.
   assign insert_en = req_fire && !taken_ff && (|last_hit);
   assign new_slot  = '{used: 1'b1, score: req_item.score, index: counter_ff};

   // A result leaves the chain when the result register is free or draining.
   assign emit_step = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign at_last   = (rank_ff == RANK_W'(keep_eff - KEEP_W'(1)));

   // Chain of cells, each wired to its neighbors.
   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      cell_ctrl_type ctrl;
      slot_type      left_slot, right_slot;
      logic          left_take;

      assign ctrl = '{active:  (KEEP_W'(i) < keep_eff),
                      is_last: (KEEP_W'(i) == keep_eff - KEEP_W'(1)),
                      clear:   csr_fire && (KEEP_W'(i) >= new_eff),
                      insert:  insert_en,
                      shift:   emit_step};
      assign last_hit[i]  = ctrl.is_last && stats[i].gt;

      if (i == 0) begin : g_head
         assign left_slot = '0;
         assign left_take = 1'b0;
      end else begin : g_body
         assign left_slot = slots[i-1];
         assign left_take = stats[i-1].take;
      end

      if (i == MAX_KEEP - 1) begin : g_tail
         assign right_slot = '0;
      end else begin : g_inner
         assign right_slot = slots[i+1];
      end

      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_slot   (new_slot),
         .left_slot  (left_slot),
         .left_take  (left_take),
         .right_slot (right_slot),
         .slot       (slots[i]),
         .stat       (stats[i])
      );
   end

   // Keep count write, index counter, overflow tracking, and start and end of reporting.
   always_comb begin
      keep_in     = keep_ff;
      counter_in  = counter_ff;
      taken_in    = taken_ff;
      overflow_in = overflow_ff;
      emit_ovf_in = emit_ovf_ff;
      busy_in     = busy_ff;
      rank_in     = rank_ff;

      if (csr_fire) begin
         keep_in = csr_data;
      end

      if (req_fire) begin
         if (taken_ff) begin
            overflow_in = 1'b1;
         end else if (counter_ff == INDEX_MAX) begin
            taken_in = 1'b1;
         end else begin
            counter_in = counter_ff + INDEX_W'(1);
         end
         // The end of the set starts reporting and resets the set state.
         if (req_item.end_of_set) begin
            emit_ovf_in = overflow_ff || taken_ff;
            counter_in  = '0;
            taken_in    = 1'b0;
            overflow_in = 1'b0;
            busy_in     = 1'b1;
            rank_in     = '0;
         end
      end

      if (emit_step) begin
         rank_in = rank_ff + RANK_W'(1);
         if (at_last) begin
            busy_in = 1'b0;
         end
      end
   end

   // Result register fed from rank 0 of the chain.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_step) begin
         rsp_valid_in       = 1'b1;
         rsp_in.rank        = rank_ff;
         rsp_in.item_index  = slots[0].used ? slots[0].index : '0;
         rsp_in.item_score  = slots[0].used ? slots[0].score : '0;
         rsp_in.slot_valid  = slots[0].used;
         rsp_in.last_rank   = at_last;
         rsp_in.overflow    = emit_ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= KEEP_RESET;
         counter_ff   <= '0;
         taken_ff     <= 1'b0;
         overflow_ff  <= 1'b0;
         emit_ovf_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keep_ff      <= keep_in;
         counter_ff   <= counter_in;
         taken_ff     <= taken_in;
         overflow_ff  <= overflow_in;
         emit_ovf_ff  <= emit_ovf_in;
         busy_ff      <= busy_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== tb/sv/tb_top_k_score_selector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for top_k_score_selector: a scoreboard class predicts
// the ranked list of each set and checks every result item. Depends on tks_pkg and top_k_score_selector.
module tb_top_k_score_selector;
   import tks_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 120;

   // Predicts the ranked list and holds the result items still to come.
   class rank_scoreboard;
      logic [SCORE_W-1:0] kept_score [MAX_KEEP];
      logic [INDEX_W-1:0] kept_index [MAX_KEEP];
      logic               kept_used  [MAX_KEEP];
      logic [INDEX_W-1:0] next_index;
      logic               index_full;
      logic               overflowed;
      logic [KEEP_W-1:0]  keep_reg;
      rsp_type            pending_ranks[$];
      int                 mismatches;

      function new();
         mismatches = 0;
         keep_reg   = KEEP_W'((MAX_KEEP < 16) ? MAX_KEEP : 16);
         clear_set();
      endfunction

      // Number of ranks in use for the current keep count.
      function int active_ranks();
         if (keep_reg == '0) return 1;
         if (keep_reg > KEEP_W'(MAX_KEEP)) return MAX_KEEP;
         return int'(keep_reg);
      endfunction

      function void clear_slots(int from);
         for (int i = from; i < MAX_KEEP; i++) begin
            kept_score[i] = '0;
            kept_index[i] = '0;
            kept_used[i]  = 1'b0;
         end
      endfunction

      function void clear_set();
         clear_slots(0);
         next_index = '0;
         index_full = 1'b0;
         overflowed = 1'b0;
      endfunction

      // A keep count write drops the slots beyond the new count.
      function void apply_keep(logic [KEEP_W-1:0] value);
         keep_reg = value;
         clear_slots(active_ranks());
      endfunction

      // Insert a score ahead of equal scores; the last rank drops off.
      function void place_score(logic [SCORE_W-1:0] score, logic [INDEX_W-1:0] index,
                                int k);
         int last_slot;
         int pos;
         last_slot = k - 1;
         if (kept_used[last_slot] && score <= kept_score[last_slot]) return;
         pos = 0;
         while (pos < last_slot && kept_used[pos] && kept_score[pos] > score) pos++;
         for (int i = last_slot; i > pos; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_index[i] = kept_index[i-1];
            kept_used[i]  = kept_used[i-1];
         end
         kept_score[pos] = score;
         kept_index[pos] = index;
         kept_used[pos]  = 1'b1;
      endfunction

      // Called for every accepted input item.
      function void note_item(req_type item);
         int      k;
         rsp_type want;
         k = active_ranks();
         if (index_full) begin
            overflowed = 1'b1;
         end else begin
            place_score(item.score, next_index, k);
            if (next_index == INDEX_MAX) index_full = 1'b1;
            else next_index = next_index + INDEX_W'(1);
         end
         if (!item.end_of_set) return;
         for (int r = 0; r < k; r++) begin
            want.rank       = RANK_W'(r);
            want.item_index = kept_used[r] ? kept_index[r] : '0;
            want.item_score = kept_used[r] ? kept_score[r] : '0;
            want.slot_valid = kept_used[r];
            want.last_rank  = (r == k - 1);
            want.overflow   = overflowed;
            pending_ranks   = {pending_ranks, want};
         end
         clear_set();
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      // Compare one accepted result item with the oldest expectation.
      task check_rank(rsp_type got);
         rsp_type want;
         if (pending_ranks.size() == 0) begin
            report($sformatf("result for rank %0d with none expected", got.rank));
            return;
         end
         want = pending_ranks.pop_front();
         if (got.rank !== want.rank)
            report($sformatf("rank got %0d expected %0d", got.rank, want.rank));
         if (got.item_index !== want.item_index)
            report($sformatf("rank %0d item_index got %0d expected %0d",
                             want.rank, got.item_index, want.item_index));
         if (got.item_score !== want.item_score)
            report($sformatf("rank %0d item_score got %0d expected %0d",
                             want.rank, got.item_score, want.item_score));
         if (got.slot_valid !== want.slot_valid)
            report($sformatf("rank %0d slot_valid got %b expected %b",
                             want.rank, got.slot_valid, want.slot_valid));
         if (got.last_rank !== want.last_rank)
            report($sformatf("rank %0d last_rank got %b expected %b",
                             want.rank, got.last_rank, want.last_rank));
         if (got.overflow !== want.overflow)
            report($sformatf("rank %0d overflow got %b expected %b",
                             want.rank, got.overflow, want.overflow));
      endtask

      task check_empty();
         if (pending_ranks.size() != 0)
            report($sformatf("%0d expected results never arrived", pending_ranks.size()));
      endtask
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_item  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_item;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [KEEP_W-1:0] csr_data  = '0;

   logic              calm         = 1'b0;
   logic              hold_request = 1'b0;
   int                stuck_cycles = 0;
   rank_scoreboard    sb;

   top_k_score_selector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watch all three channels at each edge and feed the scoreboard.
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) sb.note_item(req_item);
         if (rsp_valid && !rsp_stall) sb.check_rank(rsp_item);
         if (csr_valid && csr_ready) sb.apply_keep(csr_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            stuck_cycles <= 0;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   // End the run if nothing moves for too long.
   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result side: random stalls, or one long hold-off once it is requested.
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 36);
         end
      end
   end

   // Offer one item, with random idle cycles ahead of it, until it is taken.
   task automatic send_item(input logic [SCORE_W-1:0] score, input logic closes);
      while (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{score: score, end_of_set: closes};
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending_ranks.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Write keep_count once the block has gone quiet.
   task automatic set_keep(input logic [KEEP_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Scores drawn wide, narrow (many ties) or from the extremes.
   function automatic logic [SCORE_W-1:0] pick_score(int style);
      logic [SCORE_W-1:0] value;
      case (style)
         1:       value = SCORE_W'($urandom_range(3));
         2: begin
            case ($urandom_range(3))
               0:       value = '0;
               1:       value = SCORE_W'(1);
               2:       value = {{(SCORE_W-1){1'b1}}, 1'b0};
               default: value = '1;
            endcase
         end
         default: value = SCORE_W'($urandom);
      endcase
      return value;
   endfunction

   function automatic logic [KEEP_W-1:0] pick_keep();
      logic [KEEP_W-1:0] value;
      case ($urandom_range(4))
         0:       value = KEEP_W'($urandom_range(1));
         1:       value = KEEP_W'(16);
         2:       value = KEEP_W'($urandom_range(31, 17));
         default: value = KEEP_W'($urandom_range(16, 1));
      endcase
      return value;
   endfunction

   task automatic send_set(input int count, input int style);
      for (int i = 0; i < count; i++) send_item(pick_score(style), i == count - 1);
   endtask

   initial begin
      int count;
      int style;
      int split;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset keep count: extremes, an equal score and a partly filled list.
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0001, 1'b0);
      send_item(16'h8000, 1'b1);

      // Keep count of zero acts as one; a tie with the kept score stays out.
      set_keep(KEEP_W'(0));
      send_item(16'd5, 1'b0);
      send_item(16'd5, 1'b0);
      send_item(16'd3, 1'b0);
      send_item(16'd9, 1'b1);

      // Oversized keep count saturates; a smaller write in mid-set trims the tail.
      set_keep(KEEP_W'(31));
      send_item(16'd100, 1'b0);
      send_item(16'd200, 1'b0);
      send_item(16'd300, 1'b0);
      send_item(16'd400, 1'b0);
      set_keep(KEEP_W'(2));
      send_item(16'd250, 1'b0);
      send_item(16'd50, 1'b1);

      // A set made of its end item alone.
      set_keep(KEEP_W'(1));
      send_item(16'd0, 1'b1);

      // Full list of equal scores rejects another equal one.
      set_keep(KEEP_W'(3));
      send_item(16'd7, 1'b0);
      send_item(16'd7, 1'b0);
      send_item(16'd7, 1'b0);
      send_item(16'd7, 1'b0);
      send_item(16'd8, 1'b1);

      // Random sets with keep count changes, pressure and a calm stretch.
      for (int s = 0; s < 16; s++) begin
         count = $urandom_range(9, 1);
         style = $urandom_range(2);
         if (s == 4) hold_request <= 1'b1;
         if (s == 9) wait_drained();
         if (s == 12) calm <= 1'b1;
         if ((s < 4 || s > 7) && $urandom_range(2) == 0) set_keep(pick_keep());
         if (s > 7 && count > 2 && $urandom_range(3) == 0) begin
            split = $urandom_range(count - 1, 1);
            for (int i = 0; i < split; i++) send_item(pick_score(style), 1'b0);
            set_keep(pick_keep());
            send_set(count - split, style);
         end else begin
            send_set(count, style);
         end
      end
      calm <= 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      sb.check_empty();
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
